// ===== src/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg: shared types and microprogram of the matrix multiply engine
// Holds the control word layout, the step/condition/action codes and the
// sequencer ROM, plus the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 16;

	localparam int CFG_W     = 4;
	localparam int REG_IDX_W = 2;
	localparam int OUT_W     = 34;
	localparam int ROWCOL_W  = 3;
	localparam int OUTD_W    = OUT_W + 2 * ROWCOL_W;

	localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	typedef logic [1:0] step_t;

	localparam step_t ST_LOAD = 2'd0;
	localparam step_t ST_WAIT = 2'd1;
	localparam step_t ST_MAC  = 2'd2;
	localparam step_t ST_NEXT = 2'd3;

	typedef enum logic [1:0] {
		COND_LOAD_DONE,
		COND_DRAINED,
		COND_P_LAST,
		COND_RC_LAST
	} cond_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_CLR,
		ACT_P_INC,
		ACT_RC_INC
	} act_t;

	typedef struct packed {
		logic  in_ready;
		logic  issue;
		act_t  act;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ucode_t;

	// one product in flight through the MAC pipeline
	typedef struct packed {
		logic                issue;
		logic                first;
		logic                last;
		logic                run_last;
		logic [ROWCOL_W-1:0] row;
		logic [ROWCOL_W-1:0] col;
	} mac_tag_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		unique case (step)
			ST_LOAD: w = '{in_ready: 1'b1, issue: 1'b0, act: ACT_CLR,
				cond: COND_LOAD_DONE, tgt_t: ST_WAIT, tgt_f: ST_LOAD};
			ST_WAIT: w = '{in_ready: 1'b0, issue: 1'b0, act: ACT_NONE,
				cond: COND_DRAINED, tgt_t: ST_MAC, tgt_f: ST_WAIT};
			ST_MAC:  w = '{in_ready: 1'b0, issue: 1'b1, act: ACT_P_INC,
				cond: COND_P_LAST, tgt_t: ST_NEXT, tgt_f: ST_MAC};
			ST_NEXT: w = '{in_ready: 1'b0, issue: 1'b0, act: ACT_RC_INC,
				cond: COND_RC_LAST, tgt_t: ST_LOAD, tgt_f: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== src/matrix_multiply_engine_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit: integer matrix multiply C = A * B
// Loads A then B row-major, then streams every element of C row-major.
//
//   channel  | dir | transaction carries
//   ---------+-----+----------------------------------------------------
//   s_axis   | in  | one element of A (row-wise), then of B (row-wise)
//   m_axis   | out | one element of C with its row/column, tlast at end
//   cfg      | in  | register index 0 rows_a, 1 inner_dim, 2 cols_b
//
// Loading accepts one element per cycle. While computing C, one multiplier
// and accumulator serve all sums, and one sum is in flight at a time.
// Inputs are refused from the final element of B until the sequencer
// returns to its load step after issuing the last sum. Output stalls hold
// the sequencer in its wait step. No clearing pass after reset; a valid
// register write resets the load count, so loading restarts with A.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit #(
	parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF,
	localparam int IN_W     = ((ELEM_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [IN_W-1:0]                  s_axis_tdata,  // element
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [mme_pkg::OUTD_W-1:0]       m_axis_tdata,  // product_value, out_row, out_col
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mme_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]        cfg_data
);
	import mme_pkg::*;

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v);
		if (v == '0) return DIM_W'(1);
		if (v > CFG_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
		return DIM_W'(v);
	endfunction

	logic [CFG_W-1:0]     rows_a_q, inner_dim_q, cols_b_q;
	logic                 cfg_hit, drained;
	logic                 wr_en_a, wr_en_b;
	logic [ADDR_W-1:0]    wr_addr, rd_addr_a, rd_addr_b;
	logic [ELEM_BITS-1:0] rd_a_s1, rd_b_s1;
	mac_tag_t             tag;
	logic [OUT_W-1:0]     out_value;
	logic [ROWCOL_W-1:0]  out_row, out_col;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_ROWS_A ||
		cfg_index == REG_INNER_DIM || cfg_index == REG_COLS_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= CFG_W'(1);
			inner_dim_q <= CFG_W'(1);
			cols_b_q    <= CFG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	mme_seq #(
		.MAX_DIM (MAX_DIM)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_hit   (cfg_hit),
		.ra        (eff_size(rows_a_q)),
		.kd        (eff_size(inner_dim_q)),
		.cb        (eff_size(cols_b_q)),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.drained   (drained),
		.wr_en_a   (wr_en_a),
		.wr_en_b   (wr_en_b),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.tag       (tag)
	);

	mme_store #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_BITS (ELEM_BITS)
	) u_store (
		.clk       (clk),
		.wr_en_a   (wr_en_a),
		.wr_en_b   (wr_en_b),
		.wr_addr   (wr_addr),
		.wr_data   (s_axis_tdata[ELEM_BITS-1:0]),
		.rd_en     (tag.issue),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_a_s1   (rd_a_s1),
		.rd_b_s1   (rd_b_s1)
	);

	mme_mac #(
		.ELEM_BITS (ELEM_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s0    (tag),
		.rd_a_s1   (rd_a_s1),
		.rd_b_s1   (rd_b_s1),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (out_value),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_axis_tlast),
		.drained   (drained)
	);

	assign m_axis_tdata = {out_col, out_row, out_value};

endmodule

// ===== src/mme_seq.sv =====
// ----------------------------------------------------------------------------
// mme_seq: microcoded sequencer
// Step counter over the control ROM, load counter, row/column/inner index
// counters and the address generation for both matrix stores.
// ----------------------------------------------------------------------------
module mme_seq #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
	localparam int DIM_W  = $clog2(MAX_DIM + 1),
	localparam int DEPTH  = MAX_DIM * MAX_DIM,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_hit,
	input  logic [DIM_W-1:0]  ra,
	input  logic [DIM_W-1:0]  kd,
	input  logic [DIM_W-1:0]  cb,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              drained,
	output logic              wr_en_a,
	output logic              wr_en_b,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [ADDR_W-1:0] rd_addr_a,
	output logic [ADDR_W-1:0] rd_addr_b,
	output mme_pkg::mac_tag_t tag
);
	import mme_pkg::*;

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W = $clog2(2 * DEPTH + 1);

	step_t            step_q;
	ucode_t           uc;
	logic [IDX_W-1:0] r_q, c_q, p_q;
	logic [CNT_W-1:0] load_q, a_total, total;
	logic             load_fire, load_last, a_sel;
	logic             p_last, r_last, c_last, cond_true;

	assign uc        = ucode_rom(step_q);
	assign in_ready  = uc.in_ready;
	assign a_total   = CNT_W'(ra) * CNT_W'(kd);
	assign total     = a_total + CNT_W'(kd) * CNT_W'(cb);
	assign load_fire = in_valid & uc.in_ready;
	assign load_last = (load_q == total - CNT_W'(1));
	assign a_sel     = (load_q < a_total);

	assign wr_en_a = load_fire & a_sel;
	assign wr_en_b = load_fire & ~a_sel;
	assign wr_addr = ADDR_W'(a_sel ? load_q : load_q - a_total);

	assign p_last = (p_q == IDX_W'(kd - DIM_W'(1)));
	assign r_last = (r_q == IDX_W'(ra - DIM_W'(1)));
	assign c_last = (c_q == IDX_W'(cb - DIM_W'(1)));

	// A is row-major with kd columns, B row-major with cb columns
	assign rd_addr_a = ADDR_W'(r_q) * ADDR_W'(kd) + ADDR_W'(p_q);
	assign rd_addr_b = ADDR_W'(p_q) * ADDR_W'(cb) + ADDR_W'(c_q);

	assign tag.issue    = uc.issue;
	assign tag.first    = (p_q == '0);
	assign tag.last     = p_last;
	assign tag.run_last = r_last & c_last;
	assign tag.row      = ROWCOL_W'(r_q);
	assign tag.col      = ROWCOL_W'(c_q);

	always_comb begin
		unique case (uc.cond)
			COND_LOAD_DONE: cond_true = load_fire & load_last;
			COND_DRAINED:   cond_true = drained;
			COND_P_LAST:    cond_true = p_last;
			COND_RC_LAST:   cond_true = r_last & c_last;
			default:        cond_true = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LOAD;
			load_q <= '0;
			r_q    <= '0;
			c_q    <= '0;
			p_q    <= '0;
		end else begin
			step_q <= cond_true ? uc.tgt_t : uc.tgt_f;

			if (cfg_hit) begin
				load_q <= '0;
			end else if (load_fire) begin
				load_q <= load_last ? '0 : load_q + CNT_W'(1);
			end

			unique case (uc.act)
				ACT_CLR: begin
					r_q <= '0;
					c_q <= '0;
					p_q <= '0;
				end
				ACT_P_INC: begin
					p_q <= p_last ? '0 : p_q + IDX_W'(1);
				end
				ACT_RC_INC: begin
					if (c_last) begin
						c_q <= '0;
						r_q <= r_q + IDX_W'(1);
					end else begin
						c_q <= c_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_q < total)
		else $error("load count beyond matrix size");

	a_sum_starts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tag.issue && tag.first |-> drained)
		else $error("new sum issued with MAC pipeline or output busy");

endmodule

// ===== src/mme_store.sv =====
// ----------------------------------------------------------------------------
// mme_store: operand memories
// One memory each for A and B, row-major; one write port shared by the load
// path, one registered read port each for the MAC datapath.
// ----------------------------------------------------------------------------
module mme_store #(
	parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF,
	localparam int DEPTH    = MAX_DIM * MAX_DIM,
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en_a,
	input  logic                 wr_en_b,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [ELEM_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr_a,
	input  logic [ADDR_W-1:0]    rd_addr_b,
	output logic [ELEM_BITS-1:0] rd_a_s1,
	output logic [ELEM_BITS-1:0] rd_b_s1
);

	logic [ELEM_BITS-1:0] mem_a [DEPTH];
	logic [ELEM_BITS-1:0] mem_b [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_s1 <= mem_a[rd_addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en_b) begin
			mem_b[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_b_s1 <= mem_b[rd_addr_b];
		end
	end

endmodule

// ===== src/mme_mac.sv =====
// ----------------------------------------------------------------------------
// mme_mac: multiply-accumulate datapath and result register
// Multiplier stage, clamped accumulator stage, output saturation to the
// result width and the result register toward the output channel.
// ----------------------------------------------------------------------------
module mme_mac #(
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mme_pkg::mac_tag_t              tag_s0,
	input  logic signed [ELEM_BITS-1:0]    rd_a_s1,
	input  logic signed [ELEM_BITS-1:0]    rd_b_s1,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mme_pkg::OUT_W-1:0]      out_value,
	output logic [mme_pkg::ROWCOL_W-1:0]   out_row,
	output logic [mme_pkg::ROWCOL_W-1:0]   out_col,
	output logic                           out_last,
	output logic                           drained
);
	import mme_pkg::*;

	localparam int PROD_W = 2 * ELEM_BITS;
	localparam int ACC_W  = (PROD_W + 5 < 64) ? PROD_W + 5 : 64;

	localparam logic signed [63:0] WIDE_LIMIT = 64'sd1 <<< 61;
	localparam logic signed [63:0] OUT_MAX    = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
	localparam logic signed [63:0] OUT_MIN    = -(64'sd1 <<< (OUT_W - 1));

	function automatic logic signed [63:0] clamp_wide(input logic signed [63:0] v);
		if (v > WIDE_LIMIT) return WIDE_LIMIT;
		if (v < -WIDE_LIMIT) return -WIDE_LIMIT;
		return v;
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
		if (v > OUT_MAX) return OUT_W'(OUT_MAX);
		if (v < OUT_MIN) return OUT_W'(OUT_MIN);
		return OUT_W'(v);
	endfunction

	mac_tag_t                  tag_s1, tag_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [63:0]        prod_c, base, sum_c;
	logic                      out_valid_q, out_last_q;
	logic [OUT_W-1:0]          out_value_q;
	logic [ROWCOL_W-1:0]       out_row_q, out_col_q;

	assign prod_c = clamp_wide(64'(prod_s2));
	assign base   = tag_s2.first ? 64'sd0 : 64'(acc_q);
	assign sum_c  = clamp_wide(base + prod_c);

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_last  = out_last_q;
	assign drained   = ~tag_s1.issue & ~tag_s2.issue & ~out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			tag_s2      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (tag_s2.issue && tag_s2.last) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
		if (tag_s2.issue) begin
			acc_q <= ACC_W'(sum_c);
		end
		if (tag_s2.issue && tag_s2.last) begin
			out_value_q <= sat_out(sum_c);
			out_row_q   <= tag_s2.row;
			out_col_q   <= tag_s2.col;
			out_last_q  <= tag_s2.run_last;
		end
	end

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s2.issue && tag_s2.last |-> !out_valid_q)
		else $error("sum completed while result register still occupied");

	a_products_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s2.issue && !tag_s2.first |-> $past(tag_s2.issue))
		else $error("gap inside one sum of products");

endmodule
